### hdl/thread_queue_scheduler_defines.svh
// ---------------------------------------------------------------------------
// Thread queue scheduler assertion macros
// Shared property wrappers for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef THREAD_QUEUE_SCHEDULER_DEFINES_SVH
`define THREAD_QUEUE_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TQS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TQS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tqs_pkg.sv
// ---------------------------------------------------------------------------
// Thread queue scheduler package
// Sizes, request and result word types, codes and controller interface.
// ---------------------------------------------------------------------------
package tqs_pkg;

  localparam int THREAD_SLOTS = 4;
  localparam int MUTEX_COUNT  = 4;

  localparam int SLOT_W      = 3;
  localparam int LINK_DEPTH  = THREAD_SLOTS + 1;
  localparam int LINK_IDX_W  = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
  localparam int SLOT_IDX_W  = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int QUEUE_COUNT = 2 + MUTEX_COUNT;
  localparam int QID_W       = $clog2(QUEUE_COUNT);

  typedef logic [SLOT_W-1:0] slot_t;

  localparam slot_t SLOT_NONE = 3'd7;

  localparam logic [QID_W-1:0] QID_FREE  = QID_W'(0);
  localparam logic [QID_W-1:0] QID_READY = QID_W'(1);
  localparam logic [QID_W-1:0] QID_WAIT  = QID_W'(2);

  localparam logic [2:0] MODE_SPAWN  = 3'd0;
  localparam logic [2:0] MODE_YIELD  = 3'd1;
  localparam logic [2:0] MODE_LOCK   = 3'd2;
  localparam logic [2:0] MODE_UNLOCK = 3'd3;
  localparam logic [2:0] MODE_FINISH = 3'd4;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_FREE     = 3'd1;
  localparam logic [2:0] ST_NO_READY    = 3'd2;
  localparam logic [2:0] ST_HALTED      = 3'd3;
  localparam logic [2:0] ST_MAIN_FINISH = 3'd4;

  typedef struct packed {
    logic [2:0]         mode;
    logic [1:0]         mutex_index;
    logic [15:0]        entry_address;
    logic signed [15:0] entry_argument;
  } sched_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [2:0]         running_thread;
    logic               switched;
    logic               starts_fresh;
    logic [15:0]        start_address;
    logic signed [15:0] start_argument;
    logic [2:0]         spawned_slot;
  } sched_out_t;

  typedef struct packed {
    logic             accept;
    logic             push;
    logic             push_spawn;
    logic [QID_W-1:0] push_q;
    logic             pop;
    logic             pop_run;
    logic [QID_W-1:0] pop_q;
    logic             status_we;
    logic [2:0]       status_code;
    logic             set_halt;
    logic             set_lock;
    logic             clr_lock;
    logic             load_out;
  } tqs_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] mutex_index;
    logic       mi_ok;
    logic       halted;
    logic       free_ok;
    logic       ready_empty;
    logic       wait_empty;
    logic       mutex_locked;
    logic       running_zero;
    logic       out_busy;
  } tqs_stat_t;

  function automatic logic slot_ok(input slot_t s);
    return s <= SLOT_W'(THREAD_SLOTS);
  endfunction

endpackage

### hdl/tqs_ctrl.sv
// ---------------------------------------------------------------------------
// Thread queue scheduler controller
// Decodes each request word and sequences queue push and pop steps.
// ---------------------------------------------------------------------------
module tqs_ctrl import tqs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tqs_stat_t stat,
  output tqs_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_PUSH,
    S_POP,
    S_SPAWN_POP,
    S_SPAWN_PUSH,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [QID_W-1:0] push_q_r, push_q_nxt;
  logic [QID_W-1:0] pop_q_r, pop_q_nxt;
  logic [QID_W-1:0] wait_q;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    push_q_nxt = push_q_r;
    pop_q_nxt  = pop_q_r;
    cmd        = '0;
    wait_q     = QID_WAIT + QID_W'(stat.mutex_index);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_DONE;
        if (stat.halted) begin
          cmd.status_we   = 1'b1;
          cmd.status_code = ST_HALTED;
        end else begin
          case (stat.mode)
            MODE_SPAWN: begin
              if (!stat.free_ok) begin
                cmd.status_we   = 1'b1;
                cmd.status_code = ST_NO_FREE;
                cmd.set_halt    = 1'b1;
              end else begin
                state_nxt = S_SPAWN_POP;
              end
            end
            MODE_YIELD: begin
              push_q_nxt = QID_READY;
              pop_q_nxt  = QID_READY;
              state_nxt  = S_PUSH;
            end
            MODE_LOCK: begin
              if (stat.mi_ok) begin
                if (!stat.mutex_locked) begin
                  cmd.set_lock = 1'b1;
                end else if (stat.ready_empty) begin
                  cmd.status_we   = 1'b1;
                  cmd.status_code = ST_NO_READY;
                  cmd.set_halt    = 1'b1;
                end else begin
                  push_q_nxt = wait_q;
                  pop_q_nxt  = QID_READY;
                  state_nxt  = S_PUSH;
                end
              end
            end
            MODE_UNLOCK: begin
              if (stat.mi_ok) begin
                if (stat.wait_empty) begin
                  cmd.clr_lock = 1'b1;
                end else begin
                  push_q_nxt = QID_READY;
                  pop_q_nxt  = wait_q;
                  state_nxt  = S_PUSH;
                end
              end
            end
            MODE_FINISH: begin
              if (stat.running_zero) begin
                cmd.status_we   = 1'b1;
                cmd.status_code = ST_MAIN_FINISH;
              end else if (stat.ready_empty) begin
                cmd.status_we   = 1'b1;
                cmd.status_code = ST_NO_READY;
                cmd.set_halt    = 1'b1;
              end else begin
                push_q_nxt = QID_FREE;
                pop_q_nxt  = QID_READY;
                state_nxt  = S_PUSH;
              end
            end
            default: ;
          endcase
        end
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        cmd.push_q = push_q_r;
        state_nxt  = S_POP;
      end
      S_POP: begin
        cmd.pop     = 1'b1;
        cmd.pop_run = 1'b1;
        cmd.pop_q   = pop_q_r;
        state_nxt   = S_DONE;
      end
      S_SPAWN_POP: begin
        cmd.pop   = 1'b1;
        cmd.pop_q = QID_FREE;
        state_nxt = S_SPAWN_PUSH;
      end
      S_SPAWN_PUSH: begin
        cmd.push       = 1'b1;
        cmd.push_spawn = 1'b1;
        cmd.push_q     = QID_READY;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      push_q_r <= QID_READY;
      pop_q_r  <= QID_READY;
    end else begin
      state_r  <= state_nxt;
      push_q_r <= push_q_nxt;
      pop_q_r  <= pop_q_nxt;
    end
  end

endmodule

### hdl/tqs_datapath.sv
// ---------------------------------------------------------------------------
// Thread queue scheduler datapath
// Linked slot queues, slot data, mutex flags and the result register.
// ---------------------------------------------------------------------------
module tqs_datapath import tqs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  sched_in_t  in_data,
  input  tqs_cmd_t   cmd,
  input  logic       out_stall,
  output tqs_stat_t  stat,
  output logic       out_valid,
  output sched_out_t out_data
);

  sched_in_t req_r;

  slot_t head_r [QUEUE_COUNT];
  slot_t head_nxt [QUEUE_COUNT];
  slot_t tail_r [QUEUE_COUNT];
  slot_t tail_nxt [QUEUE_COUNT];
  slot_t link_r [LINK_DEPTH];
  slot_t link_nxt [LINK_DEPTH];

  logic [LINK_DEPTH-1:0]  started_r, started_nxt;
  logic [MUTEX_COUNT-1:0] locked_r, locked_nxt;
  logic                   halted_r, halted_nxt;
  slot_t                  running_r, running_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [15:0]        entry_r [THREAD_SLOTS];
  logic signed [15:0] arg_r [THREAD_SLOTS];

  slot_t              spawn_slot_r;
  logic [2:0]         res_status_r;
  logic               res_switched_r;
  logic               res_fresh_r;
  logic [15:0]        res_addr_r;
  logic signed [15:0] res_arg_r;
  slot_t              res_spawned_r;
  sched_out_t         out_data_r;

  slot_t                 push_slot;
  slot_t                 push_tail;
  slot_t                 pop_head;
  slot_t                 pop_next;
  slot_t                 popped;
  logic                  pop_ok;
  logic [SLOT_IDX_W-1:0] popped_idx;
  logic                  run_fresh;
  logic [15:0]           run_addr;
  logic signed [15:0]    run_arg;
  logic [QID_W-1:0]      wait_q;

  always_comb begin
    wait_q            = QID_WAIT + QID_W'(req_r.mutex_index);
    stat.mode         = req_r.mode;
    stat.mutex_index  = req_r.mutex_index;
    stat.mi_ok        = int'(req_r.mutex_index) < MUTEX_COUNT;
    stat.halted       = halted_r;
    stat.free_ok      = slot_ok(head_r[QID_FREE]) && (head_r[QID_FREE] != '0);
    stat.ready_empty  = (head_r[QID_READY] == SLOT_NONE);
    stat.wait_empty   = stat.mi_ok ? (head_r[wait_q] == SLOT_NONE) : 1'b1;
    stat.mutex_locked = stat.mi_ok ? locked_r[req_r.mutex_index] : 1'b0;
    stat.running_zero = (running_r == '0);
    stat.out_busy     = out_valid_r && out_stall;
  end

  always_comb begin
    push_slot  = cmd.push_spawn ? spawn_slot_r : running_r;
    push_tail  = tail_r[cmd.push_q];
    pop_head   = head_r[cmd.pop_q];
    pop_ok     = slot_ok(pop_head);
    pop_next   = pop_ok ? link_r[LINK_IDX_W'(pop_head)] : SLOT_NONE;
    popped     = pop_ok ? pop_head : '0;
    popped_idx = SLOT_IDX_W'(popped - SLOT_W'(1));
    run_fresh  = !started_r[LINK_IDX_W'(popped)];
    run_addr   = '0;
    run_arg    = '0;
    if (run_fresh && (popped != '0)) begin
      run_addr = entry_r[popped_idx];
      run_arg  = arg_r[popped_idx];
    end

    head_nxt      = head_r;
    tail_nxt      = tail_r;
    link_nxt      = link_r;
    started_nxt   = started_r;
    locked_nxt    = locked_r;
    halted_nxt    = halted_r || cmd.set_halt;
    running_nxt   = running_r;
    out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);

    if (cmd.set_lock) begin
      locked_nxt[req_r.mutex_index] = 1'b1;
    end
    if (cmd.clr_lock) begin
      locked_nxt[req_r.mutex_index] = 1'b0;
    end

    if (cmd.push && slot_ok(push_slot)) begin
      link_nxt[LINK_IDX_W'(push_slot)] = SLOT_NONE;
      if ((head_r[cmd.push_q] == SLOT_NONE) || !slot_ok(push_tail)) begin
        head_nxt[cmd.push_q] = push_slot;
      end else begin
        link_nxt[LINK_IDX_W'(push_tail)] = push_slot;
      end
      tail_nxt[cmd.push_q] = push_slot;
    end

    if (cmd.pop) begin
      if (!pop_ok) begin
        head_nxt[cmd.pop_q] = SLOT_NONE;
        tail_nxt[cmd.pop_q] = SLOT_NONE;
      end else begin
        head_nxt[cmd.pop_q] = pop_next;
        if (pop_next == SLOT_NONE) begin
          tail_nxt[cmd.pop_q] = SLOT_NONE;
        end
      end
      if (cmd.pop_run) begin
        running_nxt                         = popped;
        started_nxt[LINK_IDX_W'(popped)]    = 1'b1;
      end else begin
        started_nxt[LINK_IDX_W'(popped)]    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < QUEUE_COUNT; q++) begin
        head_r[q] <= (q == int'(QID_FREE)) ? SLOT_W'(1) : SLOT_NONE;
        tail_r[q] <= (q == int'(QID_FREE)) ? SLOT_W'(THREAD_SLOTS) : SLOT_NONE;
      end
      for (int k = 0; k < LINK_DEPTH; k++) begin
        link_r[k] <= (k >= 1 && k < THREAD_SLOTS) ? SLOT_W'(k + 1) : SLOT_NONE;
      end
      started_r   <= LINK_DEPTH'(1);
      locked_r    <= '0;
      halted_r    <= 1'b0;
      running_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      link_r      <= link_nxt;
      started_r   <= started_nxt;
      locked_r    <= locked_nxt;
      halted_r    <= halted_nxt;
      running_r   <= running_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r          <= in_data;
      res_status_r   <= ST_OK;
      res_switched_r <= 1'b0;
      res_fresh_r    <= 1'b0;
      res_addr_r     <= '0;
      res_arg_r      <= '0;
      res_spawned_r  <= '0;
    end
    if (cmd.status_we) begin
      res_status_r <= cmd.status_code;
    end
    if (cmd.pop && cmd.pop_run) begin
      res_switched_r <= (popped != running_r);
      res_fresh_r    <= run_fresh;
      res_addr_r     <= run_addr;
      res_arg_r      <= run_arg;
    end
    if (cmd.pop && !cmd.pop_run) begin
      spawn_slot_r        <= popped;
      res_spawned_r       <= popped;
      entry_r[popped_idx] <= req_r.entry_address;
      arg_r[popped_idx]   <= req_r.entry_argument;
    end
    if (cmd.load_out) begin
      out_data_r.status         <= res_status_r;
      out_data_r.running_thread <= running_r;
      out_data_r.switched       <= res_switched_r;
      out_data_r.starts_fresh   <= res_fresh_r;
      out_data_r.start_address  <= res_addr_r;
      out_data_r.start_argument <= res_arg_r;
      out_data_r.spawned_slot   <= res_spawned_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/thread_queue_scheduler.sv
// A request is decoded in an evaluate state and its result word is loaded in a
// done state; spawn, yield, blocking lock, handoff unlock and finish add a push
// and a pop state between them. One request is in flight at a time, so no new
// word is taken until the result is loaded into the output register.
// Synchronous active-low reset restores the free chain and the main thread.
// ---------------------------------------------------------------------------
// Thread queue scheduler
// Cooperative round-robin thread scheduler with mutex wait queues.
// ---------------------------------------------------------------------------
module thread_queue_scheduler import tqs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  sched_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output sched_out_t out_data
);

  tqs_cmd_t  cmd;
  tqs_stat_t stat;

  tqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tqs_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### hdl/tqs_checker.sv
// ---------------------------------------------------------------------------
// Thread queue scheduler checker
// Port-level properties of the scheduler, bound to the top level.
// ---------------------------------------------------------------------------
`include "thread_queue_scheduler_defines.svh"

module tqs_checker import tqs_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input sched_in_t  in_data,
  input logic       out_valid,
  input logic       out_stall,
  input sched_out_t out_data
);

  `TQS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "Stalled result word changed.")
  `TQS_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "Second word taken while busy.")
  `TQS_ASSERT_SAME(a_fresh_zero, out_valid && !out_data.starts_fresh, (out_data.start_address == '0) && (out_data.start_argument == '0), "Start fields set without a fresh start.")
  `TQS_ASSERT_SAME(a_spawn_clean, out_valid && (out_data.spawned_slot != '0), (out_data.status == ST_OK) && !out_data.switched && !out_data.starts_fresh, "Spawn result also switched threads.")

endmodule

bind thread_queue_scheduler tqs_checker u_tqs_checker (.*);
